>>> rtl/mpr_pkg.sv
// Package for the motion pad report decoder: field widths, register indexes and codes.
`default_nettype none
package mpr_pkg;

	localparam int RawW   = 8;
	localparam int JoyW   = 9;
	localparam int AccRawW = 10;
	localparam int AccW   = 11;
	localparam int SensW  = 11;
	localparam int DeltaW = 12;
	localparam int PressW = 2;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 11;

	localparam logic [RawW-1:0] OBF_KEY = 8'h17;

	localparam logic [RawW-1:0]  JOY_CENTER_RESET = 8'd114;
	localparam logic [AccRawW-1:0] ACC_OFFSET_RESET = 10'd0;
	localparam logic [SensW-1:0] SENS_RESET = 11'd10;

	localparam logic [CfgIdxW-1:0] REG_JOY_CENTER_X   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_JOY_CENTER_Y   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_ACCEL_OFFSET_X = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_ACCEL_OFFSET_Y = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_ACCEL_OFFSET_Z = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_SENS_X         = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_SENS_Y         = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_SENS_Z         = 3'd7;

	localparam logic [PressW-1:0] PRESS_NONE = 2'd0;
	localparam logic [PressW-1:0] PRESS_Z    = 2'd1;
	localparam logic [PressW-1:0] PRESS_C    = 2'd2;

	// Undo the report byte scrambling: (b xor key) + key, modulo 256.
	function automatic logic [RawW-1:0] deobf(input logic [RawW-1:0] b);
		deobf = (b ^ OBF_KEY) + OBF_KEY;
	endfunction

endpackage
`default_nettype wire

>>> rtl/mpr_axis_track.sv
// One accelerometer axis: last value and held change, updated once per transaction.
`default_nettype none
module mpr_axis_track (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              upd,
	input  wire logic signed [mpr_pkg::AccW-1:0]   acc,
	input  wire logic [mpr_pkg::SensW-1:0]         sens,
	output logic signed [mpr_pkg::DeltaW-1:0]      delta
);
	import mpr_pkg::*;

	logic signed [AccW-1:0]   prev_acc_q;
	logic signed [DeltaW-1:0] held_delta_q;
	logic signed [DeltaW-1:0] diff;
	logic [DeltaW-1:0]        mag;

	assign diff = {acc[AccW-1], acc} - {prev_acc_q[AccW-1], prev_acc_q};
	assign mag  = diff[DeltaW-1] ? (-diff) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_acc_q   <= '0;
			held_delta_q <= '0;
		end else if (upd) begin
			// A last value of zero leaves the held change untouched.
			if (prev_acc_q != '0) begin
				held_delta_q <= (mag > {1'b0, sens}) ? diff : '0;
			end
			prev_acc_q <= acc;
		end
	end

	assign delta = held_delta_q;

endmodule
`default_nettype wire

>>> rtl/motion_pad_report_decode_core.sv
// Top level of the motion pad report decoder: input register, decode, result register.
`default_nettype none
// Decodes one six-byte hand-controller report per transaction into centered joystick
// axes, offset-corrected 11-bit signed accelerations, per-axis held changes and the
// button state. One report is accepted every clock cycle while in_stall is low. A
// report is first held in the input register; its decode and threshold compare then
// feed the result and held-change registers, and the result register drives the output
// and loads only while it is empty or its transaction leaves. The held changes depend
// on the previous reports only through the per-axis last-value and held-change
// registers, which update as a result is loaded. Configuration writes take effect at
// once and are to be made while no transaction is in flight.
module motion_pad_report_decode_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [mpr_pkg::CfgIdxW-1:0]         cfg_index,
	input  wire logic [mpr_pkg::CfgDataW-1:0]        cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [mpr_pkg::RawW-1:0]            raw_joy_x,
	input  wire logic [mpr_pkg::RawW-1:0]            raw_joy_y,
	input  wire logic [mpr_pkg::RawW-1:0]            raw_acc_x_hi,
	input  wire logic [mpr_pkg::RawW-1:0]            raw_acc_y_hi,
	input  wire logic [mpr_pkg::RawW-1:0]            raw_acc_z_hi,
	input  wire logic [mpr_pkg::RawW-1:0]            raw_misc,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [mpr_pkg::JoyW-1:0]          joy_x,
	output logic signed [mpr_pkg::JoyW-1:0]          joy_y,
	output logic signed [mpr_pkg::AccW-1:0]          acc_x,
	output logic signed [mpr_pkg::AccW-1:0]          acc_y,
	output logic signed [mpr_pkg::AccW-1:0]          acc_z,
	output logic signed [mpr_pkg::DeltaW-1:0]        delta_x,
	output logic signed [mpr_pkg::DeltaW-1:0]        delta_y,
	output logic signed [mpr_pkg::DeltaW-1:0]        delta_z,
	output logic [mpr_pkg::PressW-1:0]               pressed
);
	import mpr_pkg::*;

	// Configuration registers.
	logic [RawW-1:0]    joy_center_x_q;
	logic [RawW-1:0]    joy_center_y_q;
	logic [AccRawW-1:0] accel_offset_x_q;
	logic [AccRawW-1:0] accel_offset_y_q;
	logic [AccRawW-1:0] accel_offset_z_q;
	logic [SensW-1:0]   sens_x_q;
	logic [SensW-1:0]   sens_y_q;
	logic [SensW-1:0]   sens_z_q;

	// Input register.
	logic            valid_s1;
	logic [RawW-1:0] joy_x_s1;
	logic [RawW-1:0] joy_y_s1;
	logic [RawW-1:0] acc_x_hi_s1;
	logic [RawW-1:0] acc_y_hi_s1;
	logic [RawW-1:0] acc_z_hi_s1;
	logic [RawW-1:0] misc_s1;

	// Result register.
	logic                     valid_s2;
	logic signed [JoyW-1:0]   joy_x_s2;
	logic signed [JoyW-1:0]   joy_y_s2;
	logic signed [AccW-1:0]   acc_x_s2;
	logic signed [AccW-1:0]   acc_y_s2;
	logic signed [AccW-1:0]   acc_z_s2;
	logic [PressW-1:0]        pressed_s2;

	logic out_room;
	logic adv_s1;
	logic take_in;

	logic [RawW-1:0]        misc_dec;
	logic [AccRawW-1:0]     acc_x_raw;
	logic [AccRawW-1:0]     acc_y_raw;
	logic [AccRawW-1:0]     acc_z_raw;
	logic signed [AccW-1:0] acc_x_c;
	logic signed [AccW-1:0] acc_y_c;
	logic signed [AccW-1:0] acc_z_c;
	logic signed [JoyW-1:0] joy_x_c;
	logic signed [JoyW-1:0] joy_y_c;
	logic [PressW-1:0]      pressed_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joy_center_x_q   <= JOY_CENTER_RESET;
			joy_center_y_q   <= JOY_CENTER_RESET;
			accel_offset_x_q <= ACC_OFFSET_RESET;
			accel_offset_y_q <= ACC_OFFSET_RESET;
			accel_offset_z_q <= ACC_OFFSET_RESET;
			sens_x_q         <= SENS_RESET;
			sens_y_q         <= SENS_RESET;
			sens_z_q         <= SENS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_JOY_CENTER_X:   joy_center_x_q   <= cfg_data[RawW-1:0];
				REG_JOY_CENTER_Y:   joy_center_y_q   <= cfg_data[RawW-1:0];
				REG_ACCEL_OFFSET_X: accel_offset_x_q <= cfg_data[AccRawW-1:0];
				REG_ACCEL_OFFSET_Y: accel_offset_y_q <= cfg_data[AccRawW-1:0];
				REG_ACCEL_OFFSET_Z: accel_offset_z_q <= cfg_data[AccRawW-1:0];
				REG_SENS_X:         sens_x_q         <= cfg_data[SensW-1:0];
				REG_SENS_Y:         sens_y_q         <= cfg_data[SensW-1:0];
				REG_SENS_Z:         sens_z_q         <= cfg_data[SensW-1:0];
				default: begin
				end
			endcase
		end
	end

	// The result register can load when it is empty or its transaction leaves now.
	assign out_room = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && out_room;
	assign in_stall = valid_s1 && !out_room;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in || adv_s1) begin
			valid_s1 <= take_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			joy_x_s1    <= raw_joy_x;
			joy_y_s1    <= raw_joy_y;
			acc_x_hi_s1 <= raw_acc_x_hi;
			acc_y_hi_s1 <= raw_acc_y_hi;
			acc_z_hi_s1 <= raw_acc_z_hi;
			misc_s1     <= raw_misc;
		end
	end

	assign misc_dec  = deobf(misc_s1);
	assign acc_x_raw = {deobf(acc_x_hi_s1), misc_dec[3:2]};
	assign acc_y_raw = {deobf(acc_y_hi_s1), misc_dec[5:4]};
	assign acc_z_raw = {deobf(acc_z_hi_s1), misc_dec[7:6]};

	assign acc_x_c = {1'b0, acc_x_raw} - {1'b0, accel_offset_x_q};
	assign acc_y_c = {1'b0, acc_y_raw} - {1'b0, accel_offset_y_q};
	assign acc_z_c = {1'b0, acc_z_raw} - {1'b0, accel_offset_z_q};
	assign joy_x_c = {1'b0, joy_x_s1} - {1'b0, joy_center_x_q};
	assign joy_y_c = {1'b0, joy_y_s1} - {1'b0, joy_center_y_q};

	// Button bits are active low; the z button wins when both are down.
	always_comb begin
		if (!misc_dec[0]) begin
			pressed_c = PRESS_Z;
		end else if (!misc_dec[1]) begin
			pressed_c = PRESS_C;
		end else begin
			pressed_c = PRESS_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_room) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			joy_x_s2   <= joy_x_c;
			joy_y_s2   <= joy_y_c;
			acc_x_s2   <= acc_x_c;
			acc_y_s2   <= acc_y_c;
			acc_z_s2   <= acc_z_c;
			pressed_s2 <= pressed_c;
		end
	end

	// The held changes update on the same edge that loads the result register,
	// so they belong to the transaction on the output, unless a last value of zero kept them.
	mpr_axis_track u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv_s1),
		.acc    (acc_x_c),
		.sens   (sens_x_q),
		.delta  (delta_x)
	);

	mpr_axis_track u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv_s1),
		.acc    (acc_y_c),
		.sens   (sens_y_q),
		.delta  (delta_y)
	);

	mpr_axis_track u_axis_z (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv_s1),
		.acc    (acc_z_c),
		.sens   (sens_z_q),
		.delta  (delta_z)
	);

	assign out_valid = valid_s2;
	assign joy_x     = joy_x_s2;
	assign joy_y     = joy_y_s2;
	assign acc_x     = acc_x_s2;
	assign acc_y     = acc_y_s2;
	assign acc_z     = acc_z_s2;
	assign pressed   = pressed_s2;

endmodule
`default_nettype wire
